>>> rtl/core/hrhp_pkg.sv
// Shared types, constants and helpers of the HTTP response head parser.
package hrhp_pkg;

   localparam int POS_BITS = 16;
   localparam int PW = POS_BITS + 1;
   localparam int FIELD_BITS = 16;
   localparam int RSP_DATA_BITS = 112;

   localparam logic [PW-1:0] POS_MAX = PW'(1) << POS_BITS;
   localparam logic [PW-1:0] POS_FULL = POS_MAX - PW'(1);
   localparam logic [POS_BITS-1:0] MIN_LINE = POS_BITS'(12);

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef enum logic [1:0] {
      RES_OK,
      RES_INCOMPLETE,
      RES_INVALID,
      RES_TOO_LONG
   } result_type;

   typedef struct packed {
      logic                active;
      logic                restart;
      logic [7:0]          ch;
      logic [POS_BITS-1:0] pos;
   } feed_type;

   typedef struct packed {
      logic                prefix_ok;
      logic                in_reason;
      logic [9:0]          code;
      logic [POS_BITS-1:0] reason_begin;
   } scan_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h48;
         3'd1: ch = 8'h54;
         3'd2: ch = 8'h54;
         3'd3: ch = 8'h50;
         3'd4: ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [PW-1:0] value);
      logic [PW+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, value};
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

>>> rtl/core/http_response_head_parser_unit.sv
// Top level of the HTTP response head parser: byte tracking, boundary search and result.
// The result word is registered on rsp in the cycle after the last request word is accepted.
// Throughput: one request word per cycle; only a stalled result word holds off req_tready.
// The per-byte state update and the result arithmetic sit between the state registers
// and the result register. Synchronous reset returns the parser to the start of a
// response; it also restarts by itself after each result.
module http_response_head_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [hrhp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [9:0] status_value, [25:10] reason_offset, [41:26] reason_len,
   // [57:42] headers_offset, [73:58] headers_len, [89:74] body_offset,
   // [105:90] body_len, [111:106] zero
   output logic [1:0]  rsp_tuser    // [1:0] parse_result
);
   import hrhp_pkg::*;

   logic [PW-1:0]       pos_ff, pos_in;
   logic [23:0]         recent_ff, recent_in;
   logic [POS_BITS-1:0] fle_ff, fle_in;
   logic                cr_ff, cr_in;
   logic [POS_BITS-1:0] crlf_end_ff, crlf_end_in;
   logic [POS_BITS-1:0] lf_end_ff, lf_end_in;
   logic                found_line_ff, found_line_in;
   logic                found_crlf_ff, found_crlf_in;
   logic                found_lf_ff, found_lf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   logic                accept, emit, too_long;
   logic [POS_BITS-1:0] idx, idx_plus;
   logic [7:0]          ch, p1, p2, p3;
   logic                is_lf, line_hit, crlf_hit, lf_hit;
   logic [POS_BITS-1:0] body;
   logic [PW-1:0]       total, hend, next_off, hlen, rlen, blen;
   result_type          res;
   feed_type            feed;
   scan_type            scan;

   hrhp_status_scan u_scan (
      .clock (clock),
      .reset (reset),
      .feed  (feed),
      .scan  (scan)
   );

   always_comb begin
      accept = req_tvalid && req_tready;
      emit = accept && req_tlast;
      too_long = pos_ff >= POS_FULL;
      idx = pos_ff[POS_BITS-1:0];
      idx_plus = idx + POS_BITS'(1);
      ch = req_tdata;
      p1 = recent_ff[7:0];
      p2 = recent_ff[15:8];
      p3 = recent_ff[23:16];
      is_lf = ch == CH_LF;

      line_hit = !too_long && !found_line_ff && is_lf;
      crlf_hit = !too_long && !found_crlf_ff && idx >= POS_BITS'(3) && is_lf &&
                 p1 == CH_CR && p2 == CH_LF && p3 == CH_CR;
      lf_hit = !too_long && !found_lf_ff && idx >= POS_BITS'(1) && is_lf && p1 == CH_LF;

      feed.active = accept && !too_long && !found_line_ff && idx != '0 &&
                    !(is_lf && p1 == CH_CR);
      feed.restart = emit;
      feed.ch = p1;
      feed.pos = idx - POS_BITS'(1);

      fle_in = fle_ff;
      cr_in = cr_ff;
      if (line_hit) begin
         if (idx != '0 && p1 == CH_CR) begin
            fle_in = idx - POS_BITS'(1);
            cr_in = 1'b1;
         end else begin
            fle_in = idx;
            cr_in = 1'b0;
         end
      end
      found_line_in = found_line_ff || line_hit;
      found_crlf_in = found_crlf_ff || crlf_hit;
      found_lf_in = found_lf_ff || lf_hit;
      crlf_end_in = crlf_hit ? idx_plus : crlf_end_ff;
      lf_end_in = lf_hit ? idx_plus : lf_end_ff;
      recent_in = {recent_ff[15:0], ch};
      pos_in = (pos_ff < POS_MAX) ? pos_ff + PW'(1) : pos_ff;

      total = {1'b0, idx_plus};
      body = found_crlf_in ? crlf_end_in : lf_end_in;
      hend = {1'b0, body} - (found_crlf_in ? PW'(4) : PW'(2));
      next_off = {1'b0, fle_in} + (cr_in ? PW'(2) : PW'(1));
      hlen = (hend > next_off) ? hend - next_off : '0;
      rlen = {1'b0, fle_in} - {1'b0, scan.reason_begin};
      blen = total - {1'b0, body};

      if (too_long) begin
         res = RES_TOO_LONG;
      end else if (!(found_crlf_in || found_lf_in) || !found_line_in) begin
         res = RES_INCOMPLETE;
      end else if (!scan.prefix_ok || fle_in < MIN_LINE || !scan.in_reason) begin
         res = RES_INVALID;
      end else begin
         res = RES_OK;
      end

      rsp_user_in = res;
      rsp_data_in = '0;
      if (res == RES_OK) begin
         rsp_data_in[9:0] = scan.code;
         rsp_data_in[25:10] = to_field({1'b0, scan.reason_begin});
         rsp_data_in[41:26] = to_field(rlen);
         rsp_data_in[57:42] = to_field(next_off);
         rsp_data_in[73:58] = to_field(hlen);
         rsp_data_in[89:74] = to_field({1'b0, body});
         rsp_data_in[105:90] = to_field(blen);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         pos_ff <= '0;
         recent_ff <= '0;
         fle_ff <= '0;
         cr_ff <= 1'b0;
         crlf_end_ff <= '0;
         lf_end_ff <= '0;
         found_line_ff <= 1'b0;
         found_crlf_ff <= 1'b0;
         found_lf_ff <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         recent_ff <= recent_in;
         fle_ff <= fle_in;
         cr_ff <= cr_in;
         crlf_end_ff <= crlf_end_in;
         lf_end_ff <= lf_end_in;
         found_line_ff <= found_line_in;
         found_crlf_ff <= found_crlf_in;
         found_lf_ff <= found_lf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // A result other than ok carries an all-zero data word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RES_OK |-> rsp_tdata == '0)
      else $error("non-ok result with nonzero data");

   // The last word of a response restarts byte tracking.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> pos_ff == '0 && !found_line_ff)
      else $error("parser did not restart after last word");

   // The byte counter saturates at its limit.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte counter beyond saturation");

   // A new result is never loaded while an earlier one is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result is stalled");

endmodule

>>> rtl/core/hrhp_status_scan.sv
// Status line scanner: prefix check, version skip, status digits and reason start.
module hrhp_status_scan (
   input  logic              clock,
   input  logic              reset,
   input  hrhp_pkg::feed_type feed,
   output hrhp_pkg::scan_type scan
);
   import hrhp_pkg::*;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_VERSION,
      PH_SPACES,
      PH_DIGIT2,
      PH_DIGIT3,
      PH_REASON_SP,
      PH_REASON,
      PH_BAD
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                prefix_ok_ff, prefix_ok_in;
   logic [9:0]          code_ff, code_in;
   logic [POS_BITS-1:0] rbeg_ff, rbeg_in;
   logic                is_dec;
   logic [3:0]          digit;
   logic [9:0]          code_next;
   logic [POS_BITS-1:0] pos_plus;

   always_comb begin
      is_dec = (feed.ch >= CH_ZERO) && (feed.ch <= CH_NINE);
      digit = feed.ch[3:0];
      code_next = {code_ff[6:0], 3'b000} + {code_ff[8:0], 1'b0} + {6'b000000, digit};
      pos_plus = feed.pos + POS_BITS'(1);
      phase_in = phase_ff;
      prefix_ok_in = prefix_ok_ff;
      code_in = code_ff;
      rbeg_in = rbeg_ff;
      if (feed.active) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (feed.pos < POS_BITS'(5) && feed.ch != prefix_char(feed.pos[2:0])) begin
                  prefix_ok_in = 1'b0;
               end
               if (feed.pos >= POS_BITS'(4)) begin
                  phase_in = PH_VERSION;
               end
            end
            PH_VERSION: begin
               if (feed.ch == CH_SP) begin
                  phase_in = PH_SPACES;
               end
            end
            PH_SPACES: begin
               if (feed.ch != CH_SP) begin
                  if (is_dec) begin
                     code_in = {6'b000000, digit};
                     phase_in = PH_DIGIT2;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
            end
            PH_DIGIT2, PH_DIGIT3: begin
               if (is_dec) begin
                  code_in = code_next;
                  if (phase_ff == PH_DIGIT3) begin
                     phase_in = PH_REASON_SP;
                     rbeg_in = pos_plus;
                  end else begin
                     phase_in = PH_DIGIT3;
                  end
               end else begin
                  phase_in = PH_BAD;
               end
            end
            PH_REASON_SP: begin
               if (feed.ch == CH_SP) begin
                  rbeg_in = pos_plus;
               end else begin
                  phase_in = PH_REASON;
               end
            end
            default: begin
            end
         endcase
      end
      scan.prefix_ok = prefix_ok_in;
      scan.in_reason = (phase_in == PH_REASON_SP) || (phase_in == PH_REASON);
      scan.code = code_in;
      scan.reason_begin = rbeg_in;
   end

   always_ff @(posedge clock) begin
      if (reset || feed.restart) begin
         phase_ff <= PH_PREFIX;
         prefix_ok_ff <= 1'b1;
         code_ff <= '0;
         rbeg_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         prefix_ok_ff <= prefix_ok_in;
         code_ff <= code_in;
         rbeg_ff <= rbeg_in;
      end
   end

endmodule

>>> tb/sv/tb_http_response_head_parser_unit.sv
// Self-checking testbench of the HTTP response head parser: directed heads, long body, random streams.
module tb_http_response_head_parser_unit;
   import hrhp_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;

   typedef enum logic [2:0] {
      SCAN_PREFIX,
      SCAN_VERSION,
      SCAN_GAP,
      SCAN_DIGIT2,
      SCAN_DIGIT3,
      SCAN_REASON_GAP,
      SCAN_REASON,
      SCAN_BAD
   } scan_phase_type;

   typedef struct {
      result_type  verdict;
      logic [9:0]  status;
      logic [15:0] reason_at;
      logic [15:0] reason_len;
      logic [15:0] headers_at;
      logic [15:0] headers_len;
      logic [15:0] body_at;
      logic [15:0] body_len;
   } head_summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic req_tlast = 1'b0;          // last_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // [9:0] status_value, [25:10] reason_offset, [41:26] reason_len,
   // [57:42] headers_offset, [73:58] headers_len, [89:74] body_offset,
   // [105:90] body_len, [111:106] zero
   logic [1:0] rsp_tuser;           // [1:0] parse_result

   http_response_head_parser_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   logic [7:0] http_magic [5] = '{"H", "T", "T", "P", "/"};
   string field_label [9] = '{"parse_result", "status_value", "reason_offset", "reason_len",
                              "headers_offset", "headers_len", "body_offset", "body_len",
                              "padding"};

   // Running state of the predicted parser.
   logic [PW-1:0]  seen_count;
   logic [23:0]    last_three;
   scan_phase_type scan_phase;
   logic           prefix_good;
   logic [9:0]     status_acc;
   logic [PW-1:0]  eol_at;
   logic           line_had_cr;
   logic [PW-1:0]  reason_at;
   logic [PW-1:0]  crlf_end;
   logic [PW-1:0]  lflf_end;
   logic           have_line;
   logic           have_crlf;
   logic           have_lflf;

   head_summary_type expected_heads[$];
   logic [7:0] frame[$];
   int mismatches = 0;
   int cycle_count = 0;
   int sent_bytes = 0;
   int frames_sent = 0;
   bit idle_on = 1'b1;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 99) < stall_pct)
         stall_left = $urandom_range(1, 8);
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else
         rsp_tready <= 1'b1;
   end

   task automatic clear_parser();
      seen_count = '0;
      last_three = '0;
      scan_phase = SCAN_PREFIX;
      prefix_good = 1'b1;
      status_acc = '0;
      eol_at = '0;
      line_had_cr = 1'b0;
      reason_at = '0;
      crlf_end = '0;
      lflf_end = '0;
      have_line = 1'b0;
      have_crlf = 1'b0;
      have_lflf = 1'b0;
   endtask

   // Status line scan, one byte behind the input so a CR before the first LF is never seen.
   task automatic scan_status_line(input logic [7:0] c, input logic [PW-1:0] p);
      bit digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (scan_phase)
         SCAN_PREFIX: begin
            if (p < 5 && c != http_magic[p[2:0]])
               prefix_good = 1'b0;
            if (p >= 4)
               scan_phase = SCAN_VERSION;
         end
         SCAN_VERSION: begin
            if (c == CH_SP)
               scan_phase = SCAN_GAP;
         end
         SCAN_GAP: begin
            if (digit) begin
               status_acc = 10'(c - CH_ZERO);
               scan_phase = SCAN_DIGIT2;
            end else if (c != CH_SP)
               scan_phase = SCAN_BAD;
         end
         SCAN_DIGIT2, SCAN_DIGIT3: begin
            if (!digit)
               scan_phase = SCAN_BAD;
            else begin
               status_acc = 10'(status_acc * 10 + (c - CH_ZERO));
               if (scan_phase == SCAN_DIGIT3) begin
                  scan_phase = SCAN_REASON_GAP;
                  reason_at = p + 1;
               end else
                  scan_phase = SCAN_DIGIT3;
            end
         end
         SCAN_REASON_GAP: begin
            if (c == CH_SP)
               reason_at = p + 1;
            else
               scan_phase = SCAN_REASON;
         end
         default: ;
      endcase
   endtask

   task automatic parse_byte(input logic [7:0] c, input logic last);
      logic [PW-1:0] i;
      logic [7:0] p1, p2, p3;
      logic over;
      logic [PW-1:0] total, body_pos, head_end, hdr_start;
      head_summary_type head;
      i = seen_count;
      p1 = last_three[7:0];
      p2 = last_three[15:8];
      p3 = last_three[23:16];
      over = i >= POS_FULL;
      if (!over) begin
         if (!have_line) begin
            if (c == CH_LF) begin
               if (i > 0 && p1 == CH_CR) begin
                  eol_at = i - 1;
                  line_had_cr = 1'b1;
               end else begin
                  if (i > 0)
                     scan_status_line(p1, i - 1);
                  eol_at = i;
                  line_had_cr = 1'b0;
               end
               have_line = 1'b1;
            end else if (i > 0)
               scan_status_line(p1, i - 1);
         end
         if (!have_crlf && i >= 3 && c == CH_LF && p1 == CH_CR && p2 == CH_LF && p3 == CH_CR) begin
            crlf_end = i + 1;
            have_crlf = 1'b1;
         end
         if (!have_lflf && i >= 1 && c == CH_LF && p1 == CH_LF) begin
            lflf_end = i + 1;
            have_lflf = 1'b1;
         end
      end
      last_three = {last_three[15:0], c};
      if (i < POS_MAX)
         seen_count = i + 1;
      if (!last)
         return;
      head = '{verdict: RES_OK, default: '0};
      if (over)
         head.verdict = RES_TOO_LONG;
      else if (!(have_crlf || have_lflf) || !have_line)
         head.verdict = RES_INCOMPLETE;
      else if (!prefix_good || eol_at < MIN_LINE ||
               !(scan_phase == SCAN_REASON_GAP || scan_phase == SCAN_REASON))
         head.verdict = RES_INVALID;
      else begin
         total = i + 1;
         body_pos = have_crlf ? crlf_end : lflf_end;
         head_end = have_crlf ? body_pos - 4 : body_pos - 2;
         hdr_start = eol_at + (line_had_cr ? 2 : 1);
         head.status = status_acc;
         head.reason_at = 16'(reason_at);
         head.reason_len = 16'(eol_at - reason_at);
         head.headers_at = 16'(hdr_start);
         head.headers_len = head_end > hdr_start ? 16'(head_end - hdr_start) : 16'd0;
         head.body_at = 16'(body_pos);
         head.body_len = 16'(total - body_pos);
      end
      expected_heads.push_back(head);
      clear_parser();
   endtask

   task automatic note_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   task automatic check_head();
      head_summary_type want;
      logic [15:0] want_f [9];
      logic [15:0] got_f [9];
      if (expected_heads.size() == 0) begin
         note_mismatch("result with none pending", 16'd0, 16'(rsp_tuser));
         return;
      end
      want = expected_heads.pop_front();
      want_f = '{16'(want.verdict), 16'(want.status), want.reason_at, want.reason_len,
                 want.headers_at, want.headers_len, want.body_at, want.body_len, 16'd0};
      got_f = '{16'(rsp_tuser), 16'(rsp_tdata[9:0]), rsp_tdata[25:10], rsp_tdata[41:26],
                rsp_tdata[57:42], rsp_tdata[73:58], rsp_tdata[89:74], rsp_tdata[105:90],
                16'(rsp_tdata[111:106])};
      for (int k = 0; k < 9; k++)
         if (want_f[k] !== got_f[k])
            note_mismatch(field_label[k], want_f[k], got_f[k]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         check_head();
   end

   // Entered and left at a falling edge.
   task automatic send_word(input logic [7:0] data, input logic last);
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      parse_byte(data, last);
      @(negedge clock);
   endtask

   task automatic play_frame();
      int pick;
      pick = $urandom_range(0, 2);
      gap_pct = idle_on ? (pick == 0 ? 0 : (pick == 1 ? 10 : 35)) : 0;
      pick = $urandom_range(0, 2);
      stall_pct = idle_on ? (pick == 0 ? 0 : (pick == 1 ? 10 : 35)) : 0;
      for (int k = 0; k < frame.size(); k++)
         send_word(frame[k], k == frame.size() - 1);
      sent_bytes += frame.size();
      frames_sent++;
   endtask

   task automatic add_text(input string s);
      for (int k = 0; k < s.len(); k++)
         frame.push_back(s[k]);
   endtask

   task automatic run_text(input string s);
      frame.delete();
      add_text(s);
      play_frame();
   endtask

   task automatic add_eol(input bit cr_style);
      if (cr_style ^ ($urandom_range(0, 9) == 0))
         frame.push_back(CH_CR);
      frame.push_back(CH_LF);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_SP;
         3: return 8'($urandom_range(CH_ZERO, CH_NINE));
         4: return http_magic[$urandom_range(0, 4)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] printable_byte();
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   task automatic build_random_frame();
      int kind, cut;
      bit cr_style;
      frame.delete();
      kind = $urandom_range(0, 9);
      cr_style = $urandom_range(0, 1);
      if (kind == 0) begin
         repeat ($urandom_range(1, 40)) frame.push_back(pick_byte());
      end else begin
         add_text("HTTP/");
         if ($urandom_range(0, 3) != 0)
            add_text("1.1");
         else
            repeat ($urandom_range(0, 4)) frame.push_back(printable_byte());
         repeat ($urandom_range(1, 3)) frame.push_back(CH_SP);
         repeat (3) frame.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
         repeat ($urandom_range(0, 3)) frame.push_back(CH_SP);
         repeat ($urandom_range(0, 12))
            frame.push_back($urandom_range(0, 5) == 0 ? CH_SP : printable_byte());
         add_eol(cr_style);
         repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, 16)) frame.push_back(printable_byte());
            add_eol(cr_style);
         end
         add_eol(cr_style);
         repeat ($urandom_range(0, 20)) frame.push_back(8'($urandom_range(0, 255)));
         if (kind <= 2) begin
            repeat ($urandom_range(1, 2)) frame[$urandom_range(0, frame.size() - 1)] = pick_byte();
         end else if (kind == 3) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
               void'(frame.pop_back());
         end
      end
   endtask

   task automatic test_directed_heads();
      run_text("HTTP/1.1 200 OK\r\nServer: x\r\n\r\nbody");
      run_text("HTTP/1.0 404 Not Found\n\nabc");
      // A bare double LF ahead of a CRLF pair does not win over it.
      run_text("HTTP/1.1 301 Moved\n\nX\r\n\r\nZ");
      run_text("HTTP/1.1 200 OK\r\nA: b\r\n");
      run_text("HTTP/1.1 200 OK");
      run_text("HTTX/1.1 200 OK\r\n\r\n");
      run_text("HTTP/1 20 OK\r\n\r\n");
      run_text("HTTP/1.1 2x0 Broken\r\n\r\n");
      run_text("HTTP/1.1      \r\n\r\n");
      run_text("HTTP/1.1 999   spaced reason\r\n\r\n");
      // Shortest valid line; the header end lies before the headers offset.
      run_text("HTTP/1.1 000\n\n");
      run_text("\n");
      run_text("\n\n");
      run_text("\r\n\r\n");
      run_text("HTTP/1.1 200 OK\r\n\r\n");
      run_text("HTTP/1.1 204No space\r\n\r\n");
      frame.delete();
      frame.push_back(8'h00);
      frame.push_back(8'hFF);
      add_text("\n\n");
      play_frame();
   endtask

   task automatic test_long_body();
      // A body much longer than the head, with a header line ahead of it.
      frame.delete();
      add_text("HTTP/1.1 200 OK\r\nA: b\r\n\r\n");
      while (frame.size() < 200)
         frame.push_back(8'($urandom_range(0, 255)));
      play_frame();
   endtask

   task automatic test_random_heads();
      while (sent_bytes < 400 || frames_sent < 10) begin
         build_random_frame();
         play_frame();
      end
      idle_on = 1'b0;
      repeat (6) begin
         build_random_frame();
         play_frame();
      end
   endtask

   initial begin
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_heads();
      sent_bytes = 0;
      frames_sent = 0;
      test_long_body();
      sent_bytes = 0;
      frames_sent = 0;
      test_random_heads();
      req_tvalid <= 1'b0;
      while (expected_heads.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_status_scan.sv
rtl/core/http_response_head_parser_unit.sv
tb/sv/tb_http_response_head_parser_unit.sv
